### src/aesd_pkg.sv
// Package: types, constants and GF(2^8) helpers for the AES-256 CBC decryptor.
`timescale 1ns / 1ps
package aesd_pkg;

  localparam int unsigned RoundsDefault = 14;
  localparam int unsigned KeyDepth      = 15;
  localparam int unsigned KeyAddrW      = 4;
  localparam int unsigned BlockW        = 128;
  localparam int unsigned WordW         = 64;

  typedef enum logic [1:0] {
    ACT_LOAD_KEY = 2'd0,
    ACT_LOAD_IV  = 2'd1,
    ACT_DECRYPT  = 2'd2,
    ACT_NONE     = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_FIRST = 2'd1,
    ST_ROUND = 2'd2,
    ST_OUT   = 2'd3
  } state_e;

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
  endfunction

  // Fixed multiplies for InvMixColumns: 9, 11, 13, 14.
  function automatic logic [7:0] mul9(input logic [7:0] x);
    logic [7:0] x2, x4, x8;
    x2 = xtime(x); x4 = xtime(x2); x8 = xtime(x4);
    mul9 = x8 ^ x;
  endfunction
  function automatic logic [7:0] mul11(input logic [7:0] x);
    logic [7:0] x2, x4, x8;
    x2 = xtime(x); x4 = xtime(x2); x8 = xtime(x4);
    mul11 = x8 ^ x2 ^ x;
  endfunction
  function automatic logic [7:0] mul13(input logic [7:0] x);
    logic [7:0] x2, x4, x8;
    x2 = xtime(x); x4 = xtime(x2); x8 = xtime(x4);
    mul13 = x8 ^ x4 ^ x;
  endfunction
  function automatic logic [7:0] mul14(input logic [7:0] x);
    logic [7:0] x2, x4, x8;
    x2 = xtime(x); x4 = xtime(x2); x8 = xtime(x4);
    mul14 = x8 ^ x4 ^ x2;
  endfunction

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  // Byte i of a block sits at bits 127-8i.
  function automatic logic [7:0] get_byte(input logic [127:0] b, input int i);
    get_byte = b[127 - 8*i -: 8];
  endfunction

  // InvShiftRows then InvSubBytes.
  function automatic logic [127:0] inv_shift_sub(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(4*c + r) -: 8] = INV_SBOX[get_byte(s, 4*((c - r) & 3) + r)];
      end
    end
    inv_shift_sub = t;
  endfunction

  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a, b, d, e;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a = get_byte(s, 4*c);
      b = get_byte(s, 4*c + 1);
      d = get_byte(s, 4*c + 2);
      e = get_byte(s, 4*c + 3);
      t[127 - 8*(4*c)     -: 8] = mul14(a) ^ mul11(b) ^ mul13(d) ^ mul9(e);
      t[127 - 8*(4*c + 1) -: 8] = mul9(a) ^ mul14(b) ^ mul11(d) ^ mul13(e);
      t[127 - 8*(4*c + 2) -: 8] = mul13(a) ^ mul9(b) ^ mul14(d) ^ mul11(e);
      t[127 - 8*(4*c + 3) -: 8] = mul11(a) ^ mul13(b) ^ mul9(d) ^ mul14(e);
    end
    inv_mix = t;
  endfunction

endpackage

### src/aesd_if.sv
// Interfaces: input and result channels of the decryptor.
`timescale 1ns / 1ps
interface aesd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [3:0]  key_slot;
  logic [63:0] data_hi;
  logic [63:0] data_lo;
  modport source (output valid, action, key_slot, data_hi, data_lo, input ready);
  modport sink   (input valid, action, key_slot, data_hi, data_lo, output ready);
endinterface

interface aesd_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] plain_hi;
  logic [63:0] plain_lo;
  modport source (output valid, plain_hi, plain_lo, input ready);
  modport sink   (input valid, plain_hi, plain_lo, output ready);
endinterface

### src/aesd_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module aesd_ram #(
  parameter int unsigned Width = 128,
  parameter int unsigned Depth = 15
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### src/aes256_cbc_block_decrypt.sv
// Top level: AES CBC block decryptor with round keys in a RAM and one round unit.
`timescale 1ns / 1ps
// Usage
//   in_i  : one word per action. Load-key words write round key key_slot into
//           the key RAM (slot 15 is dropped); load-IV words set the chaining
//           value; decrypt words carry one ciphertext block. Action 3 is dropped.
//   out_o : one plaintext word per decrypt word, nothing for the others.
// Sequence
//   Loads complete at the accepting edge. A decrypt does the initial key
//   add in ST_FIRST, whose read of slot Rounds is issued while idle, then
//   each round in turn through the single round unit as rnd counts down
//   from Rounds - 1 to 0, its key read for the next round issued in the
//   cycle before; the result is registered after round 0. One block at a
//   time: the next word is taken only after the output handshake has
//   returned the state machine to idle.
// Reset
//   The state machine goes idle and the chaining value clears to zero. Key
//   RAM contents are undefined until loaded; all slots 0..Rounds must be
//   loaded before a decrypt.
// Stall
//   The result holds in the output register until taken; input ready is low
//   while a block is in flight or waiting.
module aes256_cbc_block_decrypt #(
  parameter int unsigned Rounds = aesd_pkg::RoundsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  aesd_in_if.sink     in_i,
  aesd_out_if.source  out_o
);
  localparam int unsigned AW = aesd_pkg::KeyAddrW;

  aesd_pkg::state_e state_q, state_d;
  logic [AW-1:0]    rnd_q, rnd_d;
  logic [127:0]     st_q, st_d;
  logic [127:0]     ct_q;
  logic [127:0]     iv_q;
  logic [127:0]     res_q;

  logic             ram_we;
  logic [AW-1:0]    ram_raddr;
  logic [127:0]     ram_rdata;
  logic             in_fire, out_fire, start;
  logic [127:0]     in_blk;
  logic [127:0]     round_val;

  assign in_blk   = {in_i.data_hi, in_i.data_lo};
  assign in_i.ready = (state_q == aesd_pkg::ST_IDLE);
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;
  assign start    = in_fire && (in_i.action == aesd_pkg::ACT_DECRYPT);
  assign ram_we   = in_fire && (in_i.action == aesd_pkg::ACT_LOAD_KEY) &&
                    (in_i.key_slot != AW'(aesd_pkg::KeyDepth));

  aesd_ram #(.Width(aesd_pkg::BlockW), .Depth(aesd_pkg::KeyDepth)) u_keys (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_i.key_slot),
    .wdata_i (in_blk),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // One shared round: shift/sub, add key, mix unless last.
  always_comb begin
    round_val = aesd_pkg::inv_shift_sub(st_q) ^ ram_rdata;
    if (rnd_q != '0) begin
      round_val = aesd_pkg::inv_mix(round_val);
    end
  end

  // Key read address parks on slot Rounds, ready for the next block.
  always_comb begin
    state_d   = state_q;
    rnd_d     = rnd_q;
    st_d      = st_q;
    ram_raddr = AW'(Rounds);
    unique case (state_q)
      aesd_pkg::ST_IDLE: begin
        if (start) begin
          state_d = aesd_pkg::ST_FIRST;
          st_d    = in_blk;
        end
      end
      aesd_pkg::ST_FIRST: begin
        st_d      = st_q ^ ram_rdata;
        rnd_d     = AW'(Rounds - 1);
        ram_raddr = AW'(Rounds - 1);
        state_d   = aesd_pkg::ST_ROUND;
      end
      aesd_pkg::ST_ROUND: begin
        st_d      = round_val;
        rnd_d     = rnd_q - AW'(1);
        if (rnd_q == '0) begin
          state_d = aesd_pkg::ST_OUT;
        end else begin
          ram_raddr = rnd_q - AW'(1);
        end
      end
      aesd_pkg::ST_OUT: begin
        if (out_fire) begin
          state_d = aesd_pkg::ST_IDLE;
        end
      end
      default: state_d = aesd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= aesd_pkg::ST_IDLE;
      iv_q    <= '0;
    end else begin
      state_q <= state_d;
      if (in_fire && in_i.action == aesd_pkg::ACT_LOAD_IV) begin
        iv_q <= in_blk;
      end else if (state_q == aesd_pkg::ST_ROUND && rnd_q == '0) begin
        iv_q <= ct_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rnd_q <= rnd_d;
    st_q  <= st_d;
    if (start) begin
      ct_q <= in_blk;
    end
    if (state_q == aesd_pkg::ST_ROUND && rnd_q == '0) begin
      res_q <= round_val ^ iv_q;
    end
  end

  assign out_o.valid    = (state_q == aesd_pkg::ST_OUT);
  assign out_o.plain_hi = res_q[127:64];
  assign out_o.plain_lo = res_q[63:0];

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != aesd_pkg::ST_IDLE) |-> !in_i.ready)
    else $error("input taken while busy");
  a_first_to_round: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == aesd_pkg::ST_FIRST) |=> (state_q == aesd_pkg::ST_ROUND) &&
    (rnd_q == AW'(Rounds - 1)))
    else $error("bad round start");
  a_last_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == aesd_pkg::ST_ROUND && rnd_q == '0) |=> out_o.valid)
    else $error("result missing after last round");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.ready) |=> out_o.valid && $stable(res_q))
    else $error("result dropped under stall");
endmodule
